// ===== hw/rtl/bpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_pkg
// Shared types, constants and the helper function for the bitplane pattern fill.
// ----------------------------------------------------------------------------
package bpf_pkg;

  localparam int MAX_PATTERN_ROWS = 16;
  localparam int LINE_GROUPS      = 64;
  localparam int PLANES           = 4;
  localparam int PLANE_W          = 16;
  localparam int GROUP_W          = PLANES * PLANE_W;
  localparam int ROW_IDX_W        = 4;
  localparam int ROWS_W           = 5;
  localparam int COORD_W          = 10;
  localparam int COL_W            = 6;
  localparam int COLOR_W          = 4;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 10;
  localparam int Y_SPLIT          = 5;

  localparam logic [PLANE_W-1:0] FULL_MASK = 16'hffff;

  typedef enum logic [1:0] {
    MODE_REPLACE = 2'd0,
    MODE_TRANS   = 2'd1,
    MODE_XOR     = 2'd2,
    MODE_REVERSE = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_X       = 3'd0,
    CFG_RIGHT_X      = 3'd1,
    CFG_WRITE_MODE   = 3'd2,
    CFG_HOLLOW       = 3'd3,
    CFG_FG_COLOR     = 3'd4,
    CFG_BG_COLOR     = 3'd5,
    CFG_PATTERN_ROWS = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_W-1:0] left_x;
    logic [COORD_W-1:0] right_x;
    mode_e              write_mode;
    logic               hollow;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic [ROWS_W-1:0]  pattern_rows;
  } cfg_t;

  typedef struct packed {
    logic                   is_load;
    logic [ROW_IDX_W-1:0]   load_row;
    logic [PLANE_W-1:0]     row_bits;
    logic [GROUP_W-1:0]     dest;
    logic [PLANE_W-1:0]     mask;
    mode_e                  mode;
    logic [COLOR_W-1:0]     fg;
    logic [COLOR_W-1:0]     bg;
    logic [ROW_IDX_W-1:0]   rem_part;
    logic [Y_SPLIT-1:0]     y_low;
    logic [ROWS_W-1:0]      height;
  } q_entry_t;

  // five steps of restoring remainder: shift in bits msb first
  function automatic logic [ROW_IDX_W-1:0] rem_steps(input logic [ROW_IDX_W-1:0] r_in,
                                                     input logic [Y_SPLIT-1:0] bits,
                                                     input logic [ROWS_W-1:0] h);
    logic [ROWS_W-1:0] r;
    r = {1'b0, r_in};
    for (int i = Y_SPLIT - 1; i >= 0; i--) begin
      r = {r[ROWS_W-2:0], bits[i]};
      if (r >= h) begin
        r = r - h;
      end
    end
    return r[ROW_IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/bpf_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_cfg
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module bpf_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bpf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bpf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output bpf_pkg::cfg_t                  cfg_o
);
  import bpf_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LEFT_X:       cfg_d.left_x       = cfg_data_i[COORD_W-1:0];
        CFG_RIGHT_X:      cfg_d.right_x      = cfg_data_i[COORD_W-1:0];
        CFG_WRITE_MODE:   cfg_d.write_mode   = mode_e'(cfg_data_i[1:0]);
        CFG_HOLLOW:       cfg_d.hollow       = cfg_data_i[0];
        CFG_FG_COLOR:     cfg_d.fg_color     = cfg_data_i[COLOR_W-1:0];
        CFG_BG_COLOR:     cfg_d.bg_color     = cfg_data_i[COLOR_W-1:0];
        CFG_PATTERN_ROWS: cfg_d.pattern_rows = cfg_data_i[ROWS_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_x       <= '0;
      cfg_q.right_x      <= '1;
      cfg_q.write_mode   <= MODE_REPLACE;
      cfg_q.hollow       <= 1'b0;
      cfg_q.fg_color     <= COLOR_W'(1);
      cfg_q.bg_color     <= '0;
      cfg_q.pattern_rows <= ROWS_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/bpf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_front
// Classifies each transaction: edge mask, effective mode and colors, and the
// upper half of the pattern row remainder.
// ----------------------------------------------------------------------------
module bpf_front (
  input  bpf_pkg::cfg_t                  cfg_i,
  input  logic                           operation_i,
  input  logic [bpf_pkg::ROW_IDX_W-1:0]  load_row_i,
  input  logic [bpf_pkg::PLANE_W-1:0]    row_bits_i,
  input  logic [bpf_pkg::GROUP_W-1:0]    dest_group_i,
  input  logic [bpf_pkg::COL_W-1:0]      group_column_i,
  input  logic [bpf_pkg::COORD_W-1:0]    row_y_i,
  output bpf_pkg::q_entry_t              entry_o
);
  import bpf_pkg::*;

  logic [COL_W-1:0]   first_col, last_col;
  logic [PLANE_W-1:0] mask;
  logic [ROWS_W-1:0]  height;

  assign first_col = cfg_i.left_x[COORD_W-1:4];
  assign last_col  = cfg_i.right_x[COORD_W-1:4];

  always_comb begin
    mask = FULL_MASK;
    if (group_column_i == first_col) begin
      mask = mask & (FULL_MASK >> cfg_i.left_x[3:0]);
    end
    if (group_column_i == last_col) begin
      mask = mask & (FULL_MASK << (~cfg_i.right_x[3:0]));
    end
    if ((cfg_i.left_x > cfg_i.right_x) || (group_column_i < first_col) ||
        (group_column_i > last_col) || (int'(group_column_i) >= LINE_GROUPS)) begin
      mask = '0;
    end
  end

  always_comb begin
    height = cfg_i.pattern_rows;
    if (height == '0) begin
      height = ROWS_W'(1);
    end else if (int'(height) > MAX_PATTERN_ROWS) begin
      height = ROWS_W'(MAX_PATTERN_ROWS);
    end
  end

  always_comb begin
    entry_o.is_load  = !operation_i;
    entry_o.load_row = load_row_i;
    entry_o.row_bits = row_bits_i;
    entry_o.dest     = dest_group_i;
    entry_o.mask     = mask;
    entry_o.mode     = cfg_i.hollow ? MODE_REPLACE : cfg_i.write_mode;
    entry_o.fg       = cfg_i.hollow ? '0 : cfg_i.fg_color;
    entry_o.bg       = cfg_i.hollow ? '0 : cfg_i.bg_color;
    entry_o.rem_part = rem_steps('0, row_y_i[COORD_W-1:Y_SPLIT], height);
    entry_o.y_low    = row_y_i[Y_SPLIT-1:0];
    entry_o.height   = height;
  end

endmodule

// ===== hw/rtl/bpf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_queue
// Two-entry queue between the classifier and the execution stage.
// ----------------------------------------------------------------------------
module bpf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  bpf_pkg::q_entry_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output bpf_pkg::q_entry_t pop_data_o
);
  import bpf_pkg::*;

  q_entry_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/bpf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_back
// Execution stage: pattern store, final remainder, raster op, output register.
// ----------------------------------------------------------------------------
module bpf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  bpf_pkg::q_entry_t           q_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bpf_pkg::GROUP_W-1:0] new_group_o
);
  import bpf_pkg::*;

  logic [PLANE_W-1:0]   pattern_q [MAX_PATTERN_ROWS];
  logic                 out_valid_q, out_valid_d;
  logic [GROUP_W-1:0]   out_data_q, result;
  logic [ROW_IDX_W-1:0] pat_idx;
  logic [PLANE_W-1:0]   pat;
  logic                 do_pop;

  assign q_ready_o   = !out_valid_q || out_ready_i;
  assign do_pop      = q_valid_i && q_ready_o;
  assign out_valid_o = out_valid_q;
  assign new_group_o = out_data_q;

  assign pat_idx = rem_steps(q_data_i.rem_part, q_data_i.y_low, q_data_i.height);
  assign pat     = pattern_q[pat_idx];

  always_comb begin
    logic [PLANE_W-1:0] d, e, w, m;
    m      = q_data_i.mask;
    result = '0;
    for (int p = 0; p < PLANES; p++) begin
      d = q_data_i.dest[GROUP_W-1-PLANE_W*p -: PLANE_W];
      e = (q_data_i.fg[p] ? pat : '0) | (q_data_i.bg[p] ? ~pat : '0);
      case (q_data_i.mode)
        MODE_REPLACE: w = (d & ~m) | (e & m);
        MODE_TRANS:   w = (d & ~(pat & m)) | (e & pat & m);
        MODE_XOR:     w = d ^ m;
        MODE_REVERSE: w = d ^ (~pat & m);
        default:      w = d;
      endcase
      result[GROUP_W-1-PLANE_W*p -: PLANE_W] = w;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (do_pop && !q_data_i.is_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop && !q_data_i.is_load) begin
      out_data_q <= result;
    end
    if (do_pop && q_data_i.is_load) begin
      pattern_q[q_data_i.load_row] <= q_data_i.row_bits;
    end
  end

endmodule

// ===== hw/rtl/bitplane_pattern_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitplane_pattern_fill
// Pattern fill raster op for 4-plane interleaved 16-pixel groups.
//
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    operation, load_row, row_bits,
//                                     dest_group, group_column, row_y
// out      out_valid_o / out_ready_i  new_group
// cfg      cfg_valid_i / cfg_ready_o  cfg_index, cfg_data
//
// One transaction per cycle sustained while the output is not stalled; a group's
// entry is registered in the queue, and its result then in the output register.
// Pattern loads produce no result and take effect for later groups in order.
// Reset clears control state only; the pattern store is undefined until loaded.
// The two-entry queue lets input keep flowing while an output stall is absorbed.
// ----------------------------------------------------------------------------
module bitplane_pattern_fill (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic [bpf_pkg::ROW_IDX_W-1:0]  load_row_i,
  input  logic [bpf_pkg::PLANE_W-1:0]    row_bits_i,
  input  logic [bpf_pkg::GROUP_W-1:0]    dest_group_i,
  input  logic [bpf_pkg::COL_W-1:0]      group_column_i,
  input  logic [bpf_pkg::COORD_W-1:0]    row_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bpf_pkg::GROUP_W-1:0]    new_group_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bpf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bpf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bpf_pkg::*;

  cfg_t     cfg;
  q_entry_t front_entry, back_entry;
  logic     back_valid, back_ready;

  bpf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bpf_front u_front (
    .cfg_i          (cfg),
    .operation_i    (operation_i),
    .load_row_i     (load_row_i),
    .row_bits_i     (row_bits_i),
    .dest_group_i   (dest_group_i),
    .group_column_i (group_column_i),
    .row_y_i        (row_y_i),
    .entry_o        (front_entry)
  );

  bpf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_entry),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_entry)
  );

  bpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (back_valid),
    .q_ready_o   (back_ready),
    .q_data_i    (back_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .new_group_o (new_group_o)
  );

endmodule
